/* hw/rtl/varp_pkg.sv */
// Shared constants and types for the varint bit packer.
package varp_pkg;

  // Fixed field widths
  localparam int WORD_W    = 64;
  localparam int BYTE_BITS = 8;
  localparam int HDR_BITS  = 4;
  localparam int CNT_W     = HDR_BITS;

  // Default encoded word width
  localparam int DEF_WORD_BITS = 64;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;

  // Classified item pushed by the front
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] nlast;
  } push_t;

  // Item at the head of the queue
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] nlast;
  } head_t;

endpackage

/* hw/rtl/varp_in_if.sv */
// Input channel carrying one word per item.
interface varp_in_if;
  logic                       valid;
  logic                       ready;
  logic [varp_pkg::WORD_W-1:0] word_in;

  modport source (output valid, output word_in, input ready);
  modport sink   (input valid, input word_in, output ready);
endinterface

/* hw/rtl/varp_out_if.sv */
// Output channel carrying one encoded byte per item.
interface varp_out_if;
  logic                          valid;
  logic                          ready;
  logic [varp_pkg::BYTE_BITS-1:0] out_byte;
  logic                          last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

/* hw/rtl/varp_front.sv */
// Front: accept a word, build its bit stream and count its bytes.
module varp_front #(
  parameter int WORD_BITS = varp_pkg::DEF_WORD_BITS,
  parameter int NB = (varp_pkg::HDR_BITS + WORD_BITS + varp_pkg::BYTE_BITS - 1)
                     / varp_pkg::BYTE_BITS,
  parameter int SW = NB * varp_pkg::BYTE_BITS
) (
  varp_in_if.sink          word_ch,
  input  logic             q_ready,
  output varp_pkg::push_t  push,
  output logic [SW-1:0]    push_data
);

  logic [SW-1:0]                  body;
  logic [NB-1:0]                  nz;
  logic [varp_pkg::CNT_W-1:0]     nlast;

  // Place word bits LSB first right after the header slot; upper input bits drop
  always_comb begin
    body = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      body[SW-1-varp_pkg::HDR_BITS-k] = word_ch.word_in[k];
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_nz
    assign nz[j] = |body[SW-1-j*varp_pkg::BYTE_BITS -: varp_pkg::BYTE_BITS];
  end

  // Highest byte holding a set bit is the last one emitted
  always_comb begin
    nlast = '0;
    for (int j = 0; j < NB; j++) begin
      if (nz[j]) begin
        nlast = varp_pkg::CNT_W'(j);
      end
    end
  end

  assign push_data     = {nlast, body[SW-varp_pkg::HDR_BITS-1:0]};
  assign push.nlast    = nlast;
  assign push.valid    = word_ch.valid && q_ready;
  assign word_ch.ready = q_ready;

endmodule

/* hw/rtl/varp_queue.sv */
// Short queue between the front and the back.
module varp_queue #(
  parameter int SW = 72
) (
  input  logic             clk,
  input  logic             rst,
  input  varp_pkg::push_t  push,
  input  logic [SW-1:0]    push_data,
  output logic             ready,
  output varp_pkg::head_t  head,
  output logic [SW-1:0]    head_data,
  input  logic             pop
);

  localparam int PW = (varp_pkg::QDEPTH > 1) ? $clog2(varp_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(varp_pkg::QDEPTH + 1);

  logic [SW-1:0]              data_q  [varp_pkg::QDEPTH];
  logic [varp_pkg::CNT_W-1:0] nlast_q [varp_pkg::QDEPTH];
  logic [PW-1:0]              wr_ptr;
  logic [PW-1:0]              rd_ptr;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;

  always_comb begin
    count_next = count;
    if (push.valid && !pop) begin
      count_next = count + CW'(1);
    end else if (!push.valid && pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PW'(varp_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(varp_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      data_q[wr_ptr]  <= push_data;
      nlast_q[wr_ptr] <= push.nlast;
    end
  end

  assign ready      = (count != CW'(varp_pkg::QDEPTH));
  assign head.valid = (count != '0);
  assign head.nlast = nlast_q[rd_ptr];
  assign head_data  = data_q[rd_ptr];

endmodule

/* hw/rtl/varp_back.sv */
// Back: emit the head item's bytes one per cycle, while byte_ch is ready, through an output register.
module varp_back #(
  parameter int NB = 9,
  parameter int SW = NB * varp_pkg::BYTE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  varp_pkg::head_t  head,
  input  logic [SW-1:0]    head_data,
  output logic             pop,
  varp_out_if.source       byte_ch
);

  localparam int IW = (NB > 1) ? $clog2(NB) : 1;

  logic [varp_pkg::BYTE_BITS-1:0] bytes [NB];
  logic [IW-1:0]                  idx;
  logic                           advance;
  logic                           at_last;
  logic                           ovalid;
  logic [varp_pkg::BYTE_BITS-1:0] obyte;
  logic                           olast;

  for (genvar j = 0; j < NB; j++) begin : g_bytes
    assign bytes[j] = head_data[SW-1-j*varp_pkg::BYTE_BITS -: varp_pkg::BYTE_BITS];
  end

  assign advance = !ovalid || byte_ch.ready;
  assign at_last = (idx == head.nlast[IW-1:0]);
  assign pop     = advance && head.valid && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= '0;
    end else if (advance) begin
      ovalid <= head.valid;
      if (head.valid) begin
        idx <= at_last ? '0 : idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head.valid) begin
      obyte <= bytes[idx];
      olast <= at_last;
    end
  end

  assign byte_ch.valid     = ovalid;
  assign byte_ch.out_byte  = obyte;
  assign byte_ch.last_byte = olast;

endmodule

/* hw/rtl/varint64_bit_packer.sv */
// Top level of the length-prefixed varint bit packer.
// The first byte of a word goes through a queue entry and then the output register to byte_ch.
// Each word is emitted as ceil((4+L)/8) bytes, 1 to 9, where L is its significant bit
// length; they leave one at a time through the single output byte register.
// Words are taken every cycle while the two-entry queue has room.
// Reset (rst, synchronous) empties the queue and the output register; payload is not cleared.
module varint64_bit_packer #(
  parameter int WORD_BITS = varp_pkg::DEF_WORD_BITS
) (
  input  logic       clk,
  input  logic       rst,
  varp_in_if.sink    word_ch,
  varp_out_if.source byte_ch
);

  // Bytes in the longest encoding and the stream width they span
  localparam int NB = (varp_pkg::HDR_BITS + WORD_BITS + varp_pkg::BYTE_BITS - 1)
                      / varp_pkg::BYTE_BITS;
  localparam int SW = NB * varp_pkg::BYTE_BITS;

  varp_pkg::push_t  push;
  logic [SW-1:0]    push_data;
  logic             q_ready;
  varp_pkg::head_t  head;
  logic [SW-1:0]    head_data;
  logic             pop;

  // Front: classify the word (byte count) and lay out its packed stream
  varp_front #(
    .WORD_BITS (WORD_BITS),
    .NB        (NB),
    .SW        (SW)
  ) u_front (
    .word_ch   (word_ch),
    .q_ready   (q_ready),
    .push      (push),
    .push_data (push_data)
  );

  // Queue: hold classified words so the input waits on a stalled sink only once the queue is full
  varp_queue #(
    .SW (SW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .ready     (q_ready),
    .head      (head),
    .head_data (head_data),
    .pop       (pop)
  );

  // Back: walk the head word's bytes, drop it from the queue on its last byte
  varp_back #(
    .NB (NB),
    .SW (SW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_data (head_data),
    .pop       (pop),
    .byte_ch   (byte_ch)
  );

endmodule
